/* rtl/pmvo_pkg.sv */
// Shared types and constants for the Prim visit order unit.
// Used by pmvo_core and the top level; depends on nothing else.
`default_nettype none

package pmvo_pkg;

  // Fixed widths of the port fields.
  localparam int VERTEX_W   = 4;
  localparam int WEIGHT_W   = 16;
  localparam int COUNT_W    = 5;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;

  // Reset values of the configuration registers.
  localparam logic [VERTEX_W-1:0] START_VERTEX_RST = '0;
  localparam logic [COUNT_W-1:0]  VERTEX_COUNT_RST = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_VERTEX = 1'b0,
    CFG_VERTEX_COUNT = 1'b1
  } cfg_index_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_RUN   = 1'b1
  } opcode_e;

  // One result word offered by the sequencer to the output register.
  typedef struct packed {
    logic                valid;
    logic [VERTEX_W-1:0] vertex;
    logic [WEIGHT_W-1:0] key_weight;
    logic                last;
  } push_t;

endpackage

`default_nettype wire

/* rtl/pmvo_wmem.sv */
// Weight matrix memory: one write port, one read port with registered data.
// Uses no package items.
`default_nettype none

module pmvo_wmem #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            we_i,
  input  wire logic [$clog2(MAX_VERTICES)-1:0] wr_row_i,
  input  wire logic [$clog2(MAX_VERTICES)-1:0] wr_col_i,
  input  wire logic [WEIGHT_BITS-1:0]          wr_data_i,
  input  wire logic                            rd_en_i,
  input  wire logic [$clog2(MAX_VERTICES)-1:0] rd_row_i,
  input  wire logic [$clog2(MAX_VERTICES)-1:0] rd_col_i,
  output logic      [WEIGHT_BITS-1:0]          rd_data_o
);

  logic [WEIGHT_BITS-1:0] mem_q [MAX_VERTICES][MAX_VERTICES];
  logic [WEIGHT_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_row_i][wr_col_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_row_i][rd_col_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* rtl/pmvo_core.sv */
// Run sequencer: key file, visited marks and the one shared comparator
// that serves both the minimum scan and the relaxation pass. Uses pmvo_pkg.
`default_nettype none

module pmvo_core #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [pmvo_pkg::VERTEX_W-1:0]   start_vertex_i,
  input  wire logic [pmvo_pkg::COUNT_W-1:0]    vertex_count_i,
  output logic                                 busy_o,
  output logic                                 rd_en_o,
  output logic      [$clog2(MAX_VERTICES)-1:0] rd_row_o,
  output logic      [$clog2(MAX_VERTICES)-1:0] rd_col_o,
  input  wire logic [WEIGHT_BITS-1:0]          rd_data_i,
  output pmvo_pkg::push_t                      push_o,
  input  wire logic                            push_ready_i
);
  import pmvo_pkg::*;

  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam logic [WEIGHT_BITS-1:0] NO_EDGE = '1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_PUSH   = 6'b001000,
    ST_ADD    = 6'b010000,
    ST_RELAX  = 6'b100000
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [VIDX_W-1:0]      vd_q, vd_d;
  logic                   rv_q, rv_d;
  logic                   found_q, found_d;
  logic                   go_q, go_d;
  logic                   pend_valid_q, pend_valid_d;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [VIDX_W-1:0]      best_idx_q, best_idx_d;
  logic [WEIGHT_BITS-1:0] best_key_q, best_key_d;
  logic [VIDX_W-1:0]      pend_idx_q, pend_idx_d;
  logic [WEIGHT_BITS-1:0] pend_key_q, pend_key_d;
  logic [WEIGHT_BITS-1:0] key_q [MAX_VERTICES];
  logic [WEIGHT_BITS-1:0] key_d [MAX_VERTICES];

  logic [CNT_W-1:0]       nv;
  logic [VIDX_W-1:0]      cur_idx;
  logic [VIDX_W-1:0]      key_idx;
  logic [WEIGHT_BITS-1:0] key_rd;
  logic [WEIGHT_BITS-1:0] cmp_a, cmp_b;
  logic                   lt;
  logic                   cnt_live;
  logic                   relax;
  logic                   push_valid;

  // Counts above the storage size saturate.
  always_comb begin
    if (32'(vertex_count_i) > MAX_VERTICES) begin
      nv = CNT_W'(MAX_VERTICES);
    end else begin
      nv = CNT_W'(vertex_count_i);
    end
  end

  assign relax    = (state_q == ST_RELAX);
  assign cur_idx  = cnt_q[VIDX_W-1:0];
  assign cnt_live = (cnt_q < nv);
  assign key_idx  = relax ? vd_q : cur_idx;
  assign key_rd   = key_q[key_idx];

  // The shared comparator: candidate key against the running minimum while
  // scanning, matrix weight against the stored key while relaxing.
  assign cmp_a = relax ? rd_data_i : key_rd;
  assign cmp_b = relax ? key_rd : best_key_q;
  assign lt    = (cmp_a < cmp_b);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    vd_d         = vd_q;
    rv_d         = rv_q;
    found_d      = found_q;
    go_d         = go_q;
    pend_valid_d = pend_valid_q;
    visited_d    = visited_q;
    best_idx_d   = best_idx_q;
    best_key_d   = best_key_q;
    pend_idx_d   = pend_idx_q;
    pend_key_d   = pend_key_q;
    key_d        = key_q;
    rd_en_o      = 1'b0;
    push_valid   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          visited_d = '0;
          for (int k = 0; k < MAX_VERTICES; k++) begin
            key_d[k] = NO_EDGE;
          end
          if (32'(start_vertex_i) < 32'(nv)) begin
            key_d[VIDX_W'(start_vertex_i)] = '0;
          end
          pend_valid_d = 1'b0;
          cnt_d        = '0;
          found_d      = 1'b0;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_live) begin
          if (!visited_q[cur_idx] && (!found_q || lt)) begin
            best_idx_d = cur_idx;
            best_key_d = key_rd;
            found_d    = 1'b1;
          end
          cnt_d = cnt_q + CNT_W'(1);
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        go_d = found_q && (best_key_q != NO_EDGE);
        if (pend_valid_q) begin
          state_d = ST_PUSH;
        end else if (found_q && (best_key_q != NO_EDGE)) begin
          state_d = ST_ADD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PUSH: begin
        // The held vertex learns whether it is the last one only now.
        push_valid = 1'b1;
        if (push_ready_i) begin
          pend_valid_d = 1'b0;
          state_d      = go_q ? ST_ADD : ST_IDLE;
        end
      end
      ST_ADD: begin
        pend_valid_d         = 1'b1;
        pend_idx_d           = best_idx_q;
        pend_key_d           = best_key_q;
        visited_d[best_idx_q] = 1'b1;
        cnt_d                = '0;
        rv_d                 = 1'b0;
        state_d              = ST_RELAX;
      end
      ST_RELAX: begin
        // Read of column cnt is issued here; its weight is compared in the next cycle
        // against the key of the same column.
        rd_en_o = cnt_live;
        rv_d    = cnt_live;
        vd_d    = cur_idx;
        if (cnt_live) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (rv_q && !visited_q[vd_q] && lt) begin
          key_d[vd_q] = rd_data_i;
        end
        if (!cnt_live && !rv_q) begin
          cnt_d   = '0;
          found_d = 1'b0;
          state_d = ST_SCAN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      rv_q         <= 1'b0;
      found_q      <= 1'b0;
      go_q         <= 1'b0;
      pend_valid_q <= 1'b0;
      visited_q    <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      rv_q         <= rv_d;
      found_q      <= found_d;
      go_q         <= go_d;
      pend_valid_q <= pend_valid_d;
      visited_q    <= visited_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vd_q       <= vd_d;
    best_idx_q <= best_idx_d;
    best_key_q <= best_key_d;
    pend_idx_q <= pend_idx_d;
    pend_key_q <= pend_key_d;
    key_q      <= key_d;
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign rd_row_o          = best_idx_q;
  assign rd_col_o          = cur_idx;
  assign push_o.valid      = push_valid;
  assign push_o.vertex     = VERTEX_W'(pend_idx_q);
  assign push_o.key_weight = WEIGHT_W'(pend_key_q);
  assign push_o.last       = !go_q;

  a_push_has_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> pend_valid_q)
    else $error("result offered with no vertex held");

  // Marks of a finished run linger until the next run, when the count may
  // already have been rewritten.
  a_visited_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> ($countones(visited_q) <= 32'(nv)))
    else $error("more vertices visited than are active");

  a_add_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD) |=> visited_q[$past(best_idx_q)])
    else $error("added vertex not marked visited");

  a_best_unvisited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && found_q) |-> !visited_q[best_idx_q])
    else $error("scan picked a visited vertex");

endmodule

`default_nettype wire

/* rtl/prim_mst_visit_order_unit.sv */
// Top level of the Prim visit order unit: configuration registers, input
// decode and the output register. Uses pmvo_pkg, pmvo_wmem and pmvo_core.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o): a word with opcode write stores
//   one matrix weight. A word with opcode run starts a spanning tree run;
//   in_stall_o stays high until the run ends.
// - Output channel (out_valid_o / out_stall_i): one word per vertex taken,
//   in visit order, with last_o set on the final one. A run that takes no
//   vertex gives no word.
// - Steps: each taken vertex costs a scan through the single key comparator,
//   a decide step, the hand-off of the previous word (not for the first
//   vertex), a mark step, then a relaxation pass through the one matrix read
//   port; the run closes with a last scan and the hand-off of the final word.
// - The output word sits in a register, so the sequencer keeps working on
//   the next vertex while the receiver stalls; it pauses only when a second
//   word is ready and the register is still full.
// - Reset clears all control state and sets start_vertex to 0 and
//   vertex_count to 16. The weight matrix is not cleared.
// - The user must write configuration through cfg_we_i while no run is active; the block does not enforce it.
`default_nettype none

module prim_mst_visit_order_unit #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            opcode_i,
  input  wire logic [pmvo_pkg::VERTEX_W-1:0]   row_i,
  input  wire logic [pmvo_pkg::VERTEX_W-1:0]   col_i,
  input  wire logic [pmvo_pkg::WEIGHT_W-1:0]   weight_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [pmvo_pkg::VERTEX_W-1:0]   vertex_o,
  output logic      [pmvo_pkg::WEIGHT_W-1:0]   key_weight_o,
  output logic                                 last_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [pmvo_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [pmvo_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pmvo_pkg::*;

  localparam int VIDX_W = $clog2(MAX_VERTICES);

  logic [VERTEX_W-1:0] start_vertex_q;
  logic [COUNT_W-1:0]  vertex_count_q;

  logic                   in_accept;
  logic                   wr_en;
  logic                   busy;
  logic                   rd_en;
  logic [VIDX_W-1:0]      rd_row, rd_col;
  logic [WEIGHT_BITS-1:0] rd_data;
  push_t                  push;
  logic                   push_ready;

  logic                   out_valid_q, out_valid_d;
  logic [VERTEX_W-1:0]    vertex_q;
  logic [WEIGHT_W-1:0]    key_weight_q;
  logic                   last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_vertex_q <= START_VERTEX_RST;
      vertex_count_q <= VERTEX_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_START_VERTEX: start_vertex_q <= cfg_data_i[VERTEX_W-1:0];
        CFG_VERTEX_COUNT: vertex_count_q <= cfg_data_i[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !busy;

  // Positions outside the stored matrix are dropped.
  assign wr_en = in_accept && (opcode_i == OP_WRITE) &&
                 (32'(row_i) < MAX_VERTICES) && (32'(col_i) < MAX_VERTICES);

  pmvo_wmem #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_wmem (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .wr_row_i  (VIDX_W'(row_i)),
    .wr_col_i  (VIDX_W'(col_i)),
    .wr_data_i (WEIGHT_BITS'(weight_i)),
    .rd_en_i   (rd_en),
    .rd_row_i  (rd_row),
    .rd_col_i  (rd_col),
    .rd_data_o (rd_data)
  );

  pmvo_core #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (in_accept && (opcode_i == OP_RUN)),
    .start_vertex_i (start_vertex_q),
    .vertex_count_i (vertex_count_q),
    .busy_o         (busy),
    .rd_en_o        (rd_en),
    .rd_row_o       (rd_row),
    .rd_col_o       (rd_col),
    .rd_data_i      (rd_data),
    .push_o         (push),
    .push_ready_i   (push_ready)
  );

  // The output register takes a new word when empty or being drained.
  assign push_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    if (push.valid && push_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid && push_ready) begin
      vertex_q     <= push.vertex;
      key_weight_q <= push.key_weight;
      last_q       <= push.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign vertex_o     = vertex_q;
  assign key_weight_o = key_weight_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire
